### rtl/core/udsar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udsar_pkg: shared definitions of the slot and address registry
// Field widths, opcodes, status codes, sequencer states and slot entry type.
// ----------------------------------------------------------------------------
package udsar_pkg;

	localparam int unsigned NUM_SLOTS_DEF = 128;

	localparam int unsigned OP_W      = 3;
	localparam int unsigned CTRL_W    = 2;
	localparam int unsigned PORT_W    = 8;
	localparam int unsigned SPD_W     = 2;
	localparam int unsigned ADDR_W    = 7;
	localparam int unsigned SLOT_ID_W = 7;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned PKT_W     = 7;
	localparam int unsigned CNT_W     = 8;
	localparam int unsigned ADDR_NUM  = 1 << ADDR_W;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 40;

	localparam logic [OP_W-1:0] OP_CONNECT    = 3'd0;
	localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC      = 3'd2;
	localparam logic [OP_W-1:0] OP_FIND_ADDR  = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND_SLOT  = 3'd4;
	localparam logic [OP_W-1:0] OP_BIND       = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

	localparam logic [PKT_W-1:0] PKT_LOW  = 7'd8;
	localparam logic [PKT_W-1:0] PKT_FULL = 7'd64;

	localparam logic [SPD_W-1:0] LOW_SPEED_RST = 2'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LOOKUP,
		S_RESOLVE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CTRL_W-1:0] controller;
		logic [PORT_W-1:0] port;
		logic [SPD_W-1:0]  speed;
		logic [ADDR_W-1:0] address;
		logic              small_packet;
	} slot_entry_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [SLOT_ID_W-1:0] slot;
		logic [ADDR_W-1:0]    address;
		logic [CTRL_W-1:0]    controller;
		logic [PORT_W-1:0]    port;
		logic [SPD_W-1:0]     speed;
		logic [PKT_W-1:0]     pkt_size;
	} result_t;

endpackage

### rtl/core/usb_device_slot_and_address_registry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_device_slot_and_address_registry: device slot table and address map
// Takes one request item at a time and returns one result item for each.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer is idle; the result then waits
// in an output register, so the next request can be taken before it is read.
// Slot entries sit in a single-port-read RAM that is scanned one entry per
// cycle through one shared key compare, and the address map is scanned one
// bit per cycle. No clearing pass runs after reset: slot busy bits and the
// address map are flip-flops.
// ----------------------------------------------------------------------------
module usb_device_slot_and_address_registry #(
	parameter int unsigned NUM_SLOTS = udsar_pkg::NUM_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [udsar_pkg::SPD_W-1:0]      cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// opcode, controller_index, port_number, speed_code, usb_address, slot_id
	input  logic [udsar_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status, result_slot, result_address, result_controller, result_port,
	// result_speed, control_packet_size
	output logic [udsar_pkg::OUT_DATA_W-1:0] m_tdata
);
	import udsar_pkg::*;

	localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
	localparam logic [CNT_W-1:0] SLOT_END  = CNT_W'(NUM_SLOTS);
	localparam logic [CNT_W-1:0] SLOT_LAST = CNT_W'(NUM_SLOTS - 1);
	localparam logic [CNT_W-1:0] ADDR_LAST = CNT_W'(ADDR_NUM - 1);

	state_t state_q, state_d;

	logic [SPD_W-1:0]     low_speed_q;
	logic [OP_W-1:0]      op_q;
	logic [CTRL_W-1:0]    ctrl_q;
	logic [PORT_W-1:0]    port_q;
	logic [SPD_W-1:0]     spd_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [SLOT_ID_W-1:0] sid_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_SLOTS-1:0] busy_q;
	logic [ADDR_NUM-1:0]  inuse_q;
	result_t              res_q, res_d;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_q;

	logic                 rd_valid_s1;
	logic                 busy_s1;
	logic [SLOT_W-1:0]    rd_idx_s1;

	logic [OP_W-1:0]      in_op;
	logic [CTRL_W-1:0]    in_ctrl;
	logic [PORT_W-1:0]    in_port;
	logic [SPD_W-1:0]     in_spd;
	logic [ADDR_W-1:0]    in_addr;
	logic [SLOT_ID_W-1:0] in_sid;
	logic                 accept;
	logic                 in_sid_ok;

	logic [SLOT_W-1:0]    cnt_slot;
	logic                 conn_free, conn_last;
	logic                 alloc_free, alloc_last;
	logic                 mem_scan, issue, hit, scan_miss;
	logic [CTRL_W+PORT_W-1:0] key_mem, key_req;

	logic                 ram_we;
	logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
	slot_entry_t          ram_wdata, ram_rdata;
	slot_entry_t          conn_entry, bind_entry;

	logic                 res_load, cnt_inc, out_load;
	logic                 busy_set, busy_clr;
	logic [SLOT_W-1:0]    busy_idx;
	logic                 inuse_set, inuse_clr;
	logic [ADDR_W-1:0]    inuse_idx;

	function automatic result_t report_slot(input logic [SLOT_ID_W-1:0] s,
			input slot_entry_t e);
		result_t r;
		r.status     = ST_OK;
		r.slot       = s;
		r.address    = e.address;
		r.controller = e.controller;
		r.port       = e.port;
		r.speed      = e.speed;
		r.pkt_size   = e.small_packet ? PKT_LOW : PKT_FULL;
		return r;
	endfunction

	function automatic result_t status_only(input logic [STAT_W-1:0] st);
		result_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

	assign in_op   = s_tdata[2:0];
	assign in_ctrl = s_tdata[4:3];
	assign in_port = s_tdata[12:5];
	assign in_spd  = s_tdata[14:13];
	assign in_addr = s_tdata[21:15];
	assign in_sid  = s_tdata[28:22];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign in_sid_ok = (in_sid != '0) && (CNT_W'(in_sid) < SLOT_END)
		&& busy_q[in_sid[SLOT_W-1:0]];

	assign cnt_slot   = cnt_q[SLOT_W-1:0];
	assign conn_free  = !busy_q[cnt_slot];
	assign conn_last  = (cnt_q == SLOT_LAST);
	assign alloc_free = !inuse_q[cnt_q[ADDR_W-1:0]];
	assign alloc_last = (cnt_q == ADDR_LAST);

	assign mem_scan = (op_q == OP_DISCONNECT) || (op_q == OP_FIND_ADDR);
	assign issue    = (state_q == S_SCAN) && mem_scan && (cnt_q < SLOT_END);

	// shared key compare: controller and port for disconnect, else address
	assign key_mem = (op_q == OP_DISCONNECT) ? {ram_rdata.controller, ram_rdata.port}
		: (CTRL_W+PORT_W)'(ram_rdata.address);
	assign key_req = (op_q == OP_DISCONNECT) ? {ctrl_q, port_q}
		: (CTRL_W+PORT_W)'(addr_q);
	assign hit       = rd_valid_s1 && busy_s1 && (key_mem == key_req);
	assign scan_miss = !issue && !rd_valid_s1;

	always_comb begin
		conn_entry.controller   = ctrl_q;
		conn_entry.port         = port_q;
		conn_entry.speed        = spd_q;
		conn_entry.address      = '0;
		conn_entry.small_packet = (spd_q == low_speed_q);
		bind_entry              = ram_rdata;
		bind_entry.address      = addr_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_CONNECT, OP_DISCONNECT, OP_ALLOC, OP_FIND_ADDR: begin
							state_d = S_SCAN;
						end
						OP_FIND_SLOT, OP_BIND: begin
							state_d = in_sid_ok ? S_LOOKUP : S_DONE;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				case (op_q)
					OP_CONNECT: begin
						if (conn_free || conn_last) state_d = S_DONE;
					end
					OP_ALLOC: begin
						if (alloc_free || alloc_last) state_d = S_DONE;
					end
					OP_DISCONNECT, OP_FIND_ADDR: begin
						if (hit || scan_miss) state_d = S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_LOOKUP: begin
				state_d = S_RESOLVE;
			end
			S_RESOLVE: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_slot;
		ram_wdata = conn_entry;
		ram_raddr = (state_q == S_LOOKUP) ? sid_q[SLOT_W-1:0] : cnt_slot;
		res_d     = res_q;
		res_load  = 1'b0;
		cnt_inc   = 1'b0;
		out_load  = 1'b0;
		busy_set  = 1'b0;
		busy_clr  = 1'b0;
		busy_idx  = cnt_slot;
		inuse_set = 1'b0;
		inuse_clr = 1'b0;
		inuse_idx = cnt_q[ADDR_W-1:0];
		case (state_q)
			S_SCAN: begin
				case (op_q)
					OP_CONNECT: begin
						if (conn_free) begin
							ram_we   = 1'b1;
							busy_set = 1'b1;
							res_d    = report_slot(cnt_q[SLOT_ID_W-1:0], conn_entry);
							res_load = 1'b1;
						end else if (conn_last) begin
							res_d    = status_only(ST_FULL);
							res_load = 1'b1;
						end else begin
							cnt_inc = 1'b1;
						end
					end
					OP_ALLOC: begin
						if (alloc_free) begin
							inuse_set     = 1'b1;
							res_d         = status_only(ST_OK);
							res_d.address = cnt_q[ADDR_W-1:0];
							res_load      = 1'b1;
						end else if (alloc_last) begin
							res_d    = status_only(ST_FULL);
							res_load = 1'b1;
						end else begin
							cnt_inc = 1'b1;
						end
					end
					OP_DISCONNECT, OP_FIND_ADDR: begin
						cnt_inc = issue;
						if (hit) begin
							res_d    = report_slot(SLOT_ID_W'(rd_idx_s1), ram_rdata);
							res_load = 1'b1;
							if (op_q == OP_DISCONNECT) begin
								busy_clr  = 1'b1;
								busy_idx  = rd_idx_s1;
								inuse_clr = (ram_rdata.address != '0);
								inuse_idx = ram_rdata.address;
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_RESOLVE: begin
				res_load = 1'b1;
				if (op_q == OP_BIND) begin
					ram_we    = 1'b1;
					ram_waddr = sid_q[SLOT_W-1:0];
					ram_wdata = bind_entry;
					inuse_set = (addr_q != '0);
					inuse_idx = addr_q;
					res_d     = report_slot(sid_q, bind_entry);
				end else begin
					res_d = report_slot(sid_q, ram_rdata);
				end
			end
			S_DONE: begin
				out_load = !out_valid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			low_speed_q <= LOW_SPEED_RST;
			busy_q      <= '0;
			inuse_q     <= {{(ADDR_NUM-1){1'b0}}, 1'b1};
			out_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (cfg_we) low_speed_q <= cfg_wdata;
			if (busy_set) busy_q[busy_idx] <= 1'b1;
			if (busy_clr) busy_q[busy_idx] <= 1'b0;
			if (inuse_set) inuse_q[inuse_idx] <= 1'b1;
			if (inuse_clr) inuse_q[inuse_idx] <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_slot;
		busy_s1   <= busy_q[cnt_slot];
		if (accept) begin
			op_q   <= in_op;
			ctrl_q <= in_ctrl;
			port_q <= in_port;
			spd_q  <= in_spd;
			addr_q <= in_addr;
			sid_q  <= in_sid;
			cnt_q  <= CNT_W'(1);
			res_q  <= status_only(ST_NOTFOUND);
		end else begin
			if (cnt_inc) cnt_q <= cnt_q + CNT_W'(1);
			if (res_load) res_q <= res_d;
		end
		if (out_load) begin
			out_q <= {5'b0, res_q.pkt_size, res_q.speed, res_q.port, res_q.controller,
				res_q.address, res_q.slot, res_q.status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	udsar_slot_ram #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

### rtl/core/udsar_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udsar_slot_ram: slot entry store
// One write port and one registered read port over the slot entries.
// ----------------------------------------------------------------------------
module udsar_slot_ram #(
	parameter int unsigned NUM_SLOTS = udsar_pkg::NUM_SLOTS_DEF,
	localparam int unsigned SLOT_W = $clog2(NUM_SLOTS)
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [SLOT_W-1:0]      waddr,
	input  udsar_pkg::slot_entry_t wdata,
	input  logic [SLOT_W-1:0]      raddr,
	output udsar_pkg::slot_entry_t rdata
);
	import udsar_pkg::*;

	slot_entry_t mem_q [NUM_SLOTS];
	slot_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/udsar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udsar_checker: port-level checks of the slot and address registry
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module udsar_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [udsar_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [udsar_pkg::OUT_DATA_W-1:0] m_tdata
);
	import udsar_pkg::*;

	logic [STAT_W-1:0] res_status;
	logic [PKT_W-1:0]  res_pkt;

	assign res_status = m_tdata[1:0];
	assign res_pkt    = m_tdata[34:28];

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while previous item still at work");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_status != ST_OK) |-> (m_tdata[OUT_DATA_W-1:STAT_W] == '0))
		else $error("failed result carries nonzero fields");

	a_pkt_size_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_pkt == '0) || (res_pkt == PKT_LOW) || (res_pkt == PKT_FULL))
		else $error("control packet size out of range");

	a_input_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown(s_tdata[28:0]))
		else $error("request item with unknown bits");

endmodule

bind usb_device_slot_and_address_registry udsar_checker u_udsar_checker (.*);

### tb/tb_usb_device_slot_and_address_registry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_device_slot_and_address_registry: request/result stream testbench
// Each accepted request item goes through an in-bench registry model of the
// slot table and address map. The expected result is queued, and every result
// item is then compared field by field against the oldest queued one. The run
// covers directed corner requests, every low-speed code setting, a full slot
// table and a full address map, weighted random traffic, and a final
// back-to-back stretch. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_usb_device_slot_and_address_registry;
	import udsar_pkg::*;

	localparam int SLOT_COUNT = NUM_SLOTS_DEF;
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [SPD_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// registry model state
	bit               tbl_busy  [SLOT_COUNT];
	bit [CTRL_W-1:0]  tbl_ctl   [SLOT_COUNT];
	bit [PORT_W-1:0]  tbl_port  [SLOT_COUNT];
	bit [SPD_W-1:0]   tbl_speed [SLOT_COUNT];
	bit [ADDR_W-1:0]  tbl_addr  [SLOT_COUNT];
	bit               tbl_small [SLOT_COUNT];
	bit [ADDR_NUM-1:0] addr_taken = 1;
	bit [SPD_W-1:0]   low_speed_sel = LOW_SPEED_RST;

	result_t     expected_results [$];
	result_t     last_result;
	int unsigned mismatch_count = 0;
	int unsigned rx_hold = 0;
	bit          tx_gap_en = 1'b1;
	bit          rx_stall_en = 1'b1;

	usb_device_slot_and_address_registry dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	initial begin
		#3_000_000;
		$display("[usb_device_slot_and_address_registry] ERROR");
		$finish;
	end

	function automatic result_t slot_report(int s);
		result_t r;
		r            = '0;
		r.status     = ST_OK;
		r.slot       = SLOT_ID_W'(s);
		r.address    = tbl_addr[s];
		r.controller = tbl_ctl[s];
		r.port       = tbl_port[s];
		r.speed      = tbl_speed[s];
		r.pkt_size   = tbl_small[s] ? PKT_LOW : PKT_FULL;
		return r;
	endfunction

	function automatic result_t predict_registry(logic [OP_W-1:0] op, logic [CTRL_W-1:0] ctl,
			logic [PORT_W-1:0] port, logic [SPD_W-1:0] spd, logic [ADDR_W-1:0] addr,
			logic [SLOT_ID_W-1:0] sid);
		result_t r;
		bit      done;
		r        = '0;
		r.status = ST_NOTFOUND;
		done     = 1'b0;
		case (op)
			OP_CONNECT: begin
				r.status = ST_FULL;
				for (int i = 1; i < SLOT_COUNT && !done; i++) begin
					if (!tbl_busy[i]) begin
						tbl_busy[i]  = 1'b1;
						tbl_ctl[i]   = ctl;
						tbl_port[i]  = port;
						tbl_speed[i] = spd;
						tbl_addr[i]  = '0;
						tbl_small[i] = (spd == low_speed_sel);
						r            = slot_report(i);
						done         = 1'b1;
					end
				end
			end
			OP_DISCONNECT: begin
				for (int i = 1; i < SLOT_COUNT && !done; i++) begin
					if (tbl_busy[i] && tbl_ctl[i] == ctl && tbl_port[i] == port) begin
						r = slot_report(i);
						if (tbl_addr[i] != 0)
							addr_taken[tbl_addr[i]] = 1'b0;
						tbl_busy[i]  = 1'b0;
						tbl_ctl[i]   = '0;
						tbl_port[i]  = '0;
						tbl_speed[i] = '0;
						tbl_addr[i]  = '0;
						tbl_small[i] = 1'b0;
						done         = 1'b1;
					end
				end
			end
			OP_ALLOC: begin
				r.status = ST_FULL;
				for (int i = 1; i < ADDR_NUM && !done; i++) begin
					if (!addr_taken[i]) begin
						addr_taken[i] = 1'b1;
						r.status      = ST_OK;
						r.address     = ADDR_W'(i);
						done          = 1'b1;
					end
				end
			end
			OP_FIND_ADDR: begin
				for (int i = 1; i < SLOT_COUNT && !done; i++) begin
					if (tbl_busy[i] && tbl_addr[i] == addr) begin
						r    = slot_report(i);
						done = 1'b1;
					end
				end
			end
			OP_FIND_SLOT: begin
				if (sid >= 1 && int'(sid) < SLOT_COUNT && tbl_busy[sid])
					r = slot_report(int'(sid));
			end
			OP_BIND: begin
				if (sid >= 1 && int'(sid) < SLOT_COUNT && tbl_busy[sid]) begin
					tbl_addr[sid] = addr;
					if (addr != 0)
						addr_taken[addr] = 1'b1;
					r = slot_report(int'(sid));
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int pick_busy_slot();
		int start;
		int s;
		start = $urandom_range(1, SLOT_COUNT - 1);
		for (int k = 0; k < SLOT_COUNT - 1; k++) begin
			s = 1 + ((start - 1 + k) % (SLOT_COUNT - 1));
			if (tbl_busy[s])
				return s;
		end
		return 0;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			report_mismatch(name, got, want);
	endtask

	task automatic send_request(logic [OP_W-1:0] op, logic [CTRL_W-1:0] ctl,
			logic [PORT_W-1:0] port, logic [SPD_W-1:0] spd, logic [ADDR_W-1:0] addr,
			logic [SLOT_ID_W-1:0] sid);
		if (tx_gap_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, sid, addr, spd, port, ctl, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		last_result = predict_registry(op, ctl, port, spd, addr, sid);
		expected_results.push_back(last_result);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic write_low_speed_code(logic [SPD_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we        <= 1'b0;
		low_speed_sel = v;
	endtask

	task automatic send_random_request();
		logic [OP_W-1:0]      op;
		logic [CTRL_W-1:0]    ctl;
		logic [PORT_W-1:0]    port;
		logic [SPD_W-1:0]     spd;
		logic [ADDR_W-1:0]    addr;
		logic [SLOT_ID_W-1:0] sid;
		int                   pick;
		int                   s;
		ctl  = CTRL_W'($urandom);
		port = PORT_W'($urandom);
		spd  = SPD_W'($urandom);
		addr = ADDR_W'($urandom);
		sid  = SLOT_ID_W'($urandom);
		pick = $urandom_range(0, 99);
		s    = pick_busy_slot();
		if (pick < 26) begin
			op = OP_CONNECT;
			if ($urandom_range(0, 1) == 0)
				port = PORT_W'($urandom_range(0, 3));
		end else if (pick < 46) begin
			op = OP_DISCONNECT;
			if (s != 0 && $urandom_range(0, 4) != 0) begin
				ctl  = tbl_ctl[s];
				port = tbl_port[s];
			end
		end else if (pick < 58) begin
			op = OP_ALLOC;
		end else if (pick < 72) begin
			op = OP_FIND_ADDR;
			if (s != 0 && $urandom_range(0, 3) != 0)
				addr = tbl_addr[s];
		end else if (pick < 85) begin
			op = OP_FIND_SLOT;
			if (s != 0 && $urandom_range(0, 1) == 0)
				sid = SLOT_ID_W'(s);
		end else if (pick < 97) begin
			op = OP_BIND;
			if (s != 0 && $urandom_range(0, 4) != 0)
				sid = SLOT_ID_W'(s);
			if ($urandom_range(0, 2) == 0)
				addr = '0;
		end else begin
			op = ($urandom_range(0, 1) == 0) ? OP_RSVD_6 : OP_RSVD_7;
		end
		send_request(op, ctl, port, spd, addr, sid);
	endtask

	task automatic test_directed();
		send_request(OP_FIND_SLOT, 0, 0, 0, 0, 0);
		send_request(OP_FIND_SLOT, 3, 255, 3, 127, 127);
		send_request(OP_FIND_ADDR, 0, 0, 0, 0, 1);
		send_request(OP_DISCONNECT, 3, 255, 0, 0, 0);
		send_request(OP_BIND, 0, 0, 0, 5, 1);
		send_request(OP_RSVD_6, 3, 255, 3, 127, 127);
		send_request(OP_RSVD_7, 3, 255, 3, 127, 127);
		send_request(OP_CONNECT, 0, 0, LOW_SPEED_RST, 0, 0);
		send_request(OP_CONNECT, 3, 255, 3, 127, 127);
		send_request(OP_CONNECT, 3, 255, 0, 0, 0);
		send_request(OP_FIND_ADDR, 0, 0, 0, 0, 0);
		send_request(OP_ALLOC, 0, 0, 0, 0, 0);
		send_request(OP_BIND, 0, 0, 0, 1, 2);
		send_request(OP_FIND_ADDR, 0, 0, 0, 1, 0);
		send_request(OP_BIND, 0, 0, 0, 127, 3);
		send_request(OP_BIND, 0, 0, 0, 0, 1);
		send_request(OP_ALLOC, 3, 255, 3, 127, 127);
		send_request(OP_DISCONNECT, 3, 255, 0, 0, 0);
		send_request(OP_ALLOC, 0, 0, 0, 0, 0);
		send_request(OP_DISCONNECT, 3, 255, 0, 0, 0);
		send_request(OP_FIND_SLOT, 0, 0, 0, 0, 1);
		send_request(OP_FIND_SLOT, 0, 0, 0, 0, 3);
		send_request(OP_CONNECT, 1, 128, 2, 0, 0);
		send_request(OP_FIND_ADDR, 0, 0, 0, 127, 0);
		send_request(OP_DISCONNECT, 0, 0, 0, 0, 0);
		send_request(OP_DISCONNECT, 0, 0, 0, 0, 0);
		wait_for_results();
	endtask

	task automatic test_low_speed_codes();
		logic [SPD_W-1:0] codes [4];
		logic [CTRL_W-1:0] ctl;
		logic [PORT_W-1:0] port;
		codes = '{2'd0, 2'd3, 2'd2, LOW_SPEED_RST};
		foreach (codes[c]) begin
			write_low_speed_code(codes[c]);
			for (int spd = 0; spd < 4; spd++) begin
				ctl  = CTRL_W'($urandom);
				port = PORT_W'($urandom);
				send_request(OP_CONNECT, ctl, port, SPD_W'(spd), ADDR_W'($urandom), 0);
				send_request(OP_FIND_SLOT, 0, 0, 0, 0, last_result.slot);
				send_request(OP_DISCONNECT, ctl, port, 0, 0, 0);
			end
			wait_for_results();
		end
	endtask

	task automatic test_random_traffic(int count);
		for (int k = 0; k < count; k++) begin
			if (k % 50 == 0) begin
				wait_for_results();
				if ($urandom_range(0, 1) == 0)
					write_low_speed_code(SPD_W'($urandom));
				tx_gap_en   = ($urandom_range(0, 3) != 0);
				rx_stall_en = ($urandom_range(0, 3) != 0);
			end
			send_random_request();
		end
		wait_for_results();
		tx_gap_en   = 1'b1;
		rx_stall_en = 1'b1;
	endtask

	task automatic test_full_tables();
		do
			send_request(OP_CONNECT, CTRL_W'($urandom), PORT_W'($urandom), SPD_W'($urandom),
				ADDR_W'($urandom), SLOT_ID_W'($urandom));
		while (last_result.status == ST_OK);
		send_request(OP_CONNECT, 3, 255, 3, 127, 127);
		do
			send_request(OP_ALLOC, CTRL_W'($urandom), PORT_W'($urandom), SPD_W'($urandom),
				ADDR_W'($urandom), SLOT_ID_W'($urandom));
		while (last_result.status == ST_OK);
		send_request(OP_ALLOC, 0, 0, 0, 0, 0);
		for (int s = 100; s < SLOT_COUNT; s++)
			send_request(OP_BIND, 0, 0, 0, ADDR_W'(s), SLOT_ID_W'(s));
		for (int k = 0; k < 10; k++)
			send_request(OP_FIND_ADDR, 0, 0, 0, ADDR_W'($urandom_range(90, 127)), 0);
		send_request(OP_FIND_ADDR, 0, 0, 0, 0, 0);
		for (int s = 1; s < SLOT_COUNT; s++) begin
			if (tbl_busy[s])
				send_request(OP_DISCONNECT, tbl_ctl[s], tbl_port[s], 0, 0, 0);
		end
		send_request(OP_FIND_ADDR, 0, 0, 0, 0, 0);
		wait_for_results();
	endtask

	task automatic test_back_to_back(int count);
		tx_gap_en   = 1'b0;
		rx_stall_en = 1'b0;
		repeat (count) send_random_request();
		wait_for_results();
	endtask

	always @(posedge clk) begin
		if (rx_hold != 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
			rx_hold  <= $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result item with no request pending", 0, 0);
			end else begin
				want = expected_results.pop_front();
				check_field("status", int'(m_tdata[1:0]), int'(want.status));
				check_field("result_slot", int'(m_tdata[8:2]), int'(want.slot));
				check_field("result_address", int'(m_tdata[15:9]), int'(want.address));
				check_field("result_controller", int'(m_tdata[17:16]),
					int'(want.controller));
				check_field("result_port", int'(m_tdata[25:18]), int'(want.port));
				check_field("result_speed", int'(m_tdata[27:26]), int'(want.speed));
				check_field("control_packet_size", int'(m_tdata[34:28]),
					int'(want.pkt_size));
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_low_speed_codes();
		test_random_traffic(600);
		test_full_tables();
		test_back_to_back(60);
		repeat (SLOT_COUNT + 8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("[usb_device_slot_and_address_registry] OK");
		else
			$display("[usb_device_slot_and_address_registry] ERROR");
		$finish;
	end

endmodule
